FILE: hw/rtl/dwpi_pkg.sv
package dwpi_pkg;

	// field widths
	localparam int COUNT_W    = 16;
	localparam int TARGET_W   = 14;
	localparam int GAIN_W     = 16;
	localparam int LEVEL_W    = 13;
	localparam int THR_W      = 14;
	localparam int DRIVE_W    = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// limits
	localparam int OUTPUT_LIMIT   = 7199;
	localparam int INTEGRAL_LIMIT = 3500;

	// fixed point: kp Q8.8, ki and integral Q16
	localparam int PROP_FRAC_W = 8;
	localparam int FRAC_W      = 16;

	// datapath widths
	localparam int ERR_W   = COUNT_W + 1;
	localparam int PROD_W  = ERR_W + GAIN_W + 1;
	localparam int ACC_W   = PROD_W + 1;
	localparam int INTEG_W = $clog2(INTEGRAL_LIMIT) + FRAC_W + 1;
	localparam int P_W     = PROD_W - PROP_FRAC_W;
	localparam int I_W     = INTEG_W - FRAC_W;
	localparam int PI_W    = P_W + 1;
	localparam int SHAPE_W = DRIVE_W + 2;

	// register reset values
	localparam int RST_TARGET_LEFT    = 140;
	localparam int RST_TARGET_RIGHT   = 141;
	localparam int RST_PROP_GAIN      = 1152;
	localparam int RST_INTEG_GAIN     = 2621;
	localparam int RST_FEED_LEVEL     = 1600;
	localparam int RST_MIN_RUN_LEVEL  = 2000;
	localparam int RST_START_LEVEL    = 2500;
	localparam int RST_KICK_THRESHOLD = 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_LEFT    = 3'd0,
		REG_TARGET_RIGHT   = 3'd1,
		REG_PROP_GAIN      = 3'd2,
		REG_INTEG_GAIN     = 3'd3,
		REG_FEED_LEVEL     = 3'd4,
		REG_MIN_RUN_LEVEL  = 3'd5,
		REG_START_LEVEL    = 3'd6,
		REG_KICK_THRESHOLD = 3'd7
	} dwpi_reg_t;

	// stage load strobes, shared by both lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} dwpi_load_t;

	// raise a nonzero drive to at least lvl in magnitude, sign kept
	function automatic logic signed [SHAPE_W-1:0] floor_mag(
		input logic signed [SHAPE_W-1:0] d,
		input logic        [LEVEL_W-1:0] lvl
	);
		logic signed [SHAPE_W-1:0] l;
		l = $signed({{(SHAPE_W-LEVEL_W){1'b0}}, lvl});
		if (d > 0 && d < l)
			return l;
		if (d < 0 && d > -l)
			return -l;
		return d;
	endfunction

	// feedforward, run floor, stall kick and final clamp
	function automatic logic signed [DRIVE_W-1:0] shape_drive(
		input logic signed [DRIVE_W-1:0]  pi,
		input logic signed [TARGET_W-1:0] target,
		input logic        [LEVEL_W-1:0]  feed,
		input logic        [LEVEL_W-1:0]  min_run,
		input logic        [LEVEL_W-1:0]  start,
		input logic                       kick
	);
		logic signed [SHAPE_W-1:0] d;
		logic signed [SHAPE_W-1:0] f;
		logic signed [SHAPE_W-1:0] lim;
		d   = SHAPE_W'(pi);
		f   = $signed({{(SHAPE_W-LEVEL_W){1'b0}}, feed});
		lim = SHAPE_W'(OUTPUT_LIMIT);
		if (target > 0)
			d = d + f;
		else if (target < 0)
			d = d - f;
		if (target != 0)
			d = floor_mag(d, min_run);
		if (kick)
			d = floor_mag(d, start);
		if (d > lim)
			d = lim;
		else if (d < -lim)
			d = -lim;
		return $signed(d[DRIVE_W-1:0]);
	endfunction

endpackage

FILE: hw/rtl/dwpi_in_if.sv
interface dwpi_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dwpi_pkg::COUNT_W-1:0] left_count;
	logic signed [dwpi_pkg::COUNT_W-1:0] right_count;

	modport source(output valid, output left_count, output right_count, input ready);
	modport sink(input valid, input left_count, input right_count, output ready);
endinterface

FILE: hw/rtl/dwpi_out_if.sv
interface dwpi_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dwpi_pkg::DRIVE_W-1:0] left_drive;
	logic signed [dwpi_pkg::DRIVE_W-1:0] right_drive;

	modport source(output valid, output left_drive, output right_drive, input ready);
	modport sink(input valid, input left_drive, input right_drive, output ready);
endinterface

FILE: hw/rtl/dwpi_lane.sv
module dwpi_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dwpi_pkg::dwpi_load_t                  ld,
	input  logic signed [dwpi_pkg::COUNT_W-1:0]   count,
	input  logic signed [dwpi_pkg::TARGET_W-1:0]  target,
	input  logic        [dwpi_pkg::GAIN_W-1:0]    prop_gain,
	input  logic        [dwpi_pkg::GAIN_W-1:0]    integ_gain,
	input  logic        [dwpi_pkg::THR_W-1:0]     kick_threshold,
	output logic signed [dwpi_pkg::DRIVE_W-1:0]   pi_s4,
	output logic                                  kick_s4
);

	localparam int ERR_W   = dwpi_pkg::ERR_W;
	localparam int PROD_W  = dwpi_pkg::PROD_W;
	localparam int ACC_W   = dwpi_pkg::ACC_W;
	localparam int INTEG_W = dwpi_pkg::INTEG_W;
	localparam int P_W     = dwpi_pkg::P_W;
	localparam int I_W     = dwpi_pkg::I_W;
	localparam int PI_W    = dwpi_pkg::PI_W;
	localparam int FRAC_W  = dwpi_pkg::FRAC_W;
	localparam int PFRAC_W = dwpi_pkg::PROP_FRAC_W;
	localparam int GAIN_W_EXT = dwpi_pkg::GAIN_W + 1;

	localparam logic signed [ACC_W-1:0] ILIM =
		ACC_W'(longint'(dwpi_pkg::INTEGRAL_LIMIT) << FRAC_W);
	localparam logic signed [PI_W-1:0] OLIM = PI_W'(dwpi_pkg::OUTPUT_LIMIT);
	localparam logic signed [PROD_W-1:0] P_RND = PROD_W'((1 << PFRAC_W) - 1);
	localparam logic signed [INTEG_W-1:0] I_RND = INTEG_W'((1 << FRAC_W) - 1);

	// stage 1: error
	logic signed [ERR_W-1:0]   err_s1;
	logic                      zero_s1;
	// stage 2: products
	logic signed [PROD_W-1:0]  ki_prod_s2;
	logic signed [PROD_W-1:0]  kp_prod_s2;
	logic                      kick_s2;
	// stage 3: proportional term, integral updated
	logic signed [P_W-1:0]     p_s3;
	logic                      kick_s3;
	logic signed [INTEG_W-1:0] integral_q;

	logic signed [GAIN_W_EXT-1:0] ki_ext;
	logic signed [GAIN_W_EXT-1:0] kp_ext;

	logic        [ERR_W-1:0]   err_mag;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_sat;
	logic signed [PROD_W-1:0]  kp_adj;
	logic signed [INTEG_W-1:0] i_adj;
	logic signed [I_W-1:0]     i_val;
	logic signed [PI_W-1:0]    pi_sum;
	logic signed [PI_W-1:0]    pi_sat;

	assign ki_ext  = $signed({1'b0, integ_gain});
	assign kp_ext  = $signed({1'b0, prop_gain});
	assign err_mag = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);

	always_comb begin
		acc = ACC_W'(integral_q) + ACC_W'(ki_prod_s2);
		if (acc > ILIM)
			acc_sat = ILIM;
		else if (acc < -ILIM)
			acc_sat = -ILIM;
		else
			acc_sat = acc;
	end

	// truncation toward zero: bias negatives before the shift
	assign kp_adj = kp_prod_s2 + (kp_prod_s2[PROD_W-1] ? P_RND : '0);
	assign i_adj  = integral_q + (integral_q[INTEG_W-1] ? I_RND : '0);
	assign i_val  = $signed(i_adj[INTEG_W-1:FRAC_W]);

	always_comb begin
		pi_sum = PI_W'(p_s3) + PI_W'(i_val);
		if (pi_sum > OLIM)
			pi_sat = OLIM;
		else if (pi_sum < -OLIM)
			pi_sat = -OLIM;
		else
			pi_sat = pi_sum;
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			err_s1  <= ERR_W'(target) - ERR_W'(count);
			zero_s1 <= (count == '0);
		end
		if (ld.s2) begin
			ki_prod_s2 <= ki_ext * err_s1;
			kp_prod_s2 <= kp_ext * err_s1;
			kick_s2    <= zero_s1 && (err_mag > ERR_W'(kick_threshold));
		end
		if (ld.s3) begin
			p_s3    <= $signed(kp_adj[PROD_W-1:PFRAC_W]);
			kick_s3 <= kick_s2;
		end
		if (ld.s4) begin
			pi_s4   <= $signed(pi_sat[dwpi_pkg::DRIVE_W-1:0]);
			kick_s4 <= kick_s3;
		end
	end

	// integral stays valid for the item in stage 3 until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (ld.s3) begin
			integral_q <= $signed(acc_sat[INTEG_W-1:0]);
		end
	end

endmodule

FILE: hw/rtl/dwpi_merge.sv
module dwpi_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  vld_s4,
	output logic                                  take,
	input  logic signed [dwpi_pkg::DRIVE_W-1:0]   left_pi,
	input  logic                                  left_kick,
	input  logic signed [dwpi_pkg::DRIVE_W-1:0]   right_pi,
	input  logic                                  right_kick,
	input  logic signed [dwpi_pkg::TARGET_W-1:0]  target_left,
	input  logic signed [dwpi_pkg::TARGET_W-1:0]  target_right,
	input  logic        [dwpi_pkg::LEVEL_W-1:0]   feed_level,
	input  logic        [dwpi_pkg::LEVEL_W-1:0]   min_run_level,
	input  logic        [dwpi_pkg::LEVEL_W-1:0]   start_level,
	dwpi_out_if.source                            drives
);

	// output register free, or being emptied this cycle
	assign take = !drives.valid || drives.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drives.valid <= 1'b0;
		end else if (vld_s4 && take) begin
			drives.valid <= 1'b1;
		end else if (drives.ready) begin
			drives.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && take) begin
			drives.left_drive <= dwpi_pkg::shape_drive(left_pi, target_left, feed_level,
				min_run_level, start_level, left_kick);
			drives.right_drive <= dwpi_pkg::shape_drive(right_pi, target_right, feed_level,
				min_run_level, start_level, right_kick);
		end
	end

endmodule

FILE: hw/rtl/dual_wheel_pi_speed_control.sv
// channel   dir  modport             beat payload
// --------  ---  ------------------  -------------------------------------------
// counts    in   dwpi_in_if.sink     left_count, right_count (16 b signed each)
// drives    out  dwpi_out_if.source  left_drive, right_drive (14 b signed each)
// cfg       in   plain write port    cfg_wen, cfg_index (3 b), cfg_data (16 b)
//
// One beat per cycle sustained while drives are taken; a result passes from lane
// stage 1 through three more lane stages, then the output register.
// The loop that sets the rate is the integral add-and-clamp in lane stage 3,
// which is combinational into integral_q, so consecutive ticks follow back to back.
// arst_n clears the stage valids, the integrals and loads the register defaults.
// Ready runs back through full stages in the same cycle, so the input stalls
// only when every stage is full; empty stages keep accepting, so a beat is
// still taken while a finished result waits at the output.
module dual_wheel_pi_speed_control (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [dwpi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dwpi_pkg::CFG_DATA_W-1:0]       cfg_data,
	dwpi_in_if.sink                               counts,
	dwpi_out_if.source                            drives
);

	// configuration registers
	logic signed [dwpi_pkg::TARGET_W-1:0] target_left_q;
	logic signed [dwpi_pkg::TARGET_W-1:0] target_right_q;
	logic        [dwpi_pkg::GAIN_W-1:0]   prop_gain_q;
	logic        [dwpi_pkg::GAIN_W-1:0]   integ_gain_q;
	logic        [dwpi_pkg::LEVEL_W-1:0]  feed_level_q;
	logic        [dwpi_pkg::LEVEL_W-1:0]  min_run_level_q;
	logic        [dwpi_pkg::LEVEL_W-1:0]  start_level_q;
	logic        [dwpi_pkg::THR_W-1:0]    kick_threshold_q;

	// stage occupancy
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic take;

	dwpi_pkg::dwpi_load_t ld;

	logic signed [dwpi_pkg::DRIVE_W-1:0] left_pi, right_pi;
	logic                                left_kick, right_kick;

	// register writes: fields beyond a register's width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_left_q    <= dwpi_pkg::TARGET_W'(dwpi_pkg::RST_TARGET_LEFT);
			target_right_q   <= dwpi_pkg::TARGET_W'(dwpi_pkg::RST_TARGET_RIGHT);
			prop_gain_q      <= dwpi_pkg::GAIN_W'(dwpi_pkg::RST_PROP_GAIN);
			integ_gain_q     <= dwpi_pkg::GAIN_W'(dwpi_pkg::RST_INTEG_GAIN);
			feed_level_q     <= dwpi_pkg::LEVEL_W'(dwpi_pkg::RST_FEED_LEVEL);
			min_run_level_q  <= dwpi_pkg::LEVEL_W'(dwpi_pkg::RST_MIN_RUN_LEVEL);
			start_level_q    <= dwpi_pkg::LEVEL_W'(dwpi_pkg::RST_START_LEVEL);
			kick_threshold_q <= dwpi_pkg::THR_W'(dwpi_pkg::RST_KICK_THRESHOLD);
		end else if (cfg_wen) begin
			unique case (dwpi_pkg::dwpi_reg_t'(cfg_index))
				dwpi_pkg::REG_TARGET_LEFT: begin
					target_left_q <= $signed(cfg_data[dwpi_pkg::TARGET_W-1:0]);
				end
				dwpi_pkg::REG_TARGET_RIGHT: begin
					target_right_q <= $signed(cfg_data[dwpi_pkg::TARGET_W-1:0]);
				end
				dwpi_pkg::REG_PROP_GAIN: begin
					prop_gain_q <= cfg_data[dwpi_pkg::GAIN_W-1:0];
				end
				dwpi_pkg::REG_INTEG_GAIN: begin
					integ_gain_q <= cfg_data[dwpi_pkg::GAIN_W-1:0];
				end
				dwpi_pkg::REG_FEED_LEVEL: begin
					feed_level_q <= cfg_data[dwpi_pkg::LEVEL_W-1:0];
				end
				dwpi_pkg::REG_MIN_RUN_LEVEL: begin
					min_run_level_q <= cfg_data[dwpi_pkg::LEVEL_W-1:0];
				end
				dwpi_pkg::REG_START_LEVEL: begin
					start_level_q <= cfg_data[dwpi_pkg::LEVEL_W-1:0];
				end
				dwpi_pkg::REG_KICK_THRESHOLD: begin
					kick_threshold_q <= cfg_data[dwpi_pkg::THR_W-1:0];
				end
			endcase
		end
	end

	// a stage can load when it is empty or its beat moves on this cycle
	assign rdy_s4 = !vld_s4 || take;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign counts.ready = rdy_s1;

	assign ld.s1 = counts.valid && rdy_s1;
	assign ld.s2 = vld_s1 && rdy_s2;
	assign ld.s3 = vld_s2 && rdy_s3;
	assign ld.s4 = vld_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= counts.valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_s3)
				vld_s3 <= vld_s2;
			if (rdy_s4)
				vld_s4 <= vld_s3;
		end
	end

	// one lane per wheel, same gains and thresholds
	dwpi_lane u_lane_left (
		.clk            (clk),
		.arst_n         (arst_n),
		.ld             (ld),
		.count          (counts.left_count),
		.target         (target_left_q),
		.prop_gain      (prop_gain_q),
		.integ_gain     (integ_gain_q),
		.kick_threshold (kick_threshold_q),
		.pi_s4          (left_pi),
		.kick_s4        (left_kick)
	);

	dwpi_lane u_lane_right (
		.clk            (clk),
		.arst_n         (arst_n),
		.ld             (ld),
		.count          (counts.right_count),
		.target         (target_right_q),
		.prop_gain      (prop_gain_q),
		.integ_gain     (integ_gain_q),
		.kick_threshold (kick_threshold_q),
		.pi_s4          (right_pi),
		.kick_s4        (right_kick)
	);

	// shaping of both drives and the output register
	dwpi_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_s4        (vld_s4),
		.take          (take),
		.left_pi       (left_pi),
		.left_kick     (left_kick),
		.right_pi      (right_pi),
		.right_kick    (right_kick),
		.target_left   (target_left_q),
		.target_right  (target_right_q),
		.feed_level    (feed_level_q),
		.min_run_level (min_run_level_q),
		.start_level   (start_level_q),
		.drives        (drives)
	);

	// drives never leave the output limit
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drives.valid |-> ($signed(drives.left_drive) <= dwpi_pkg::OUTPUT_LIMIT &&
			$signed(drives.left_drive) >= -dwpi_pkg::OUTPUT_LIMIT &&
			$signed(drives.right_drive) <= dwpi_pkg::OUTPUT_LIMIT &&
			$signed(drives.right_drive) >= -dwpi_pkg::OUTPUT_LIMIT))
		else $error("drive outside output limit");

	// an empty first stage must always take a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> counts.ready)
		else $error("input stalled with stage 1 empty");

	// an accepted beat occupies stage 1 next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(counts.valid && counts.ready) |=> vld_s1)
		else $error("accepted beat lost");

	// a result only appears out of an occupied last stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drives.valid) |-> $past(vld_s4))
		else $error("result without a beat in stage 4");

endmodule
